@@ hw/rtl/fastcgi_record_stream_parser_unit_assert.svh @@
// assertion macros used by the fastcgi record parser queue module
`ifndef FASTCGI_RECORD_STREAM_PARSER_UNIT_ASSERT_SVH
`define FASTCGI_RECORD_STREAM_PARSER_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define FRSP_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// property checked on every clock edge, reset included
`define FRSP_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error(msg);

`endif

@@ hw/rtl/frsp_pkg.sv @@
// shared types and constants of the fastcgi record parser
package frsp_pkg;

	// record header and record types
	localparam int HEADER_LEN = 8;
	localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
	localparam logic [7:0] TYPE_STDOUT      = 8'd6;
	localparam logic [7:0] TYPE_STDERR      = 8'd7;

	// stream kind codes on the result
	localparam logic [1:0] KIND_STDOUT = 2'd0;
	localparam logic [1:0] KIND_STDERR = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	// queue between parser and output stage
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// parser phase
	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_CONTENT = 2'd1,
		PH_PADDING = 2'd2
	} phase_t;

	// one result request
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [1:0]  kind;
		logic [15:0] request_tag;
		logic [31:0] app_status;
		logic [7:0]  protocol_status;
		logic        record_last;
	} rec_t;

endpackage

@@ hw/rtl/frsp_front.sv @@
// front part: header collection, content and padding counting, result building
module frsp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      stream_byte,
	input  logic            in_valid,
	input  logic            fifo_full,
	output logic            in_stall,
	output logic            push,
	output frsp_pkg::rec_t  push_rec
);

	// header byte positions
	localparam logic [2:0] HDR_TYPE    = 3'd1;
	localparam logic [2:0] HDR_REQ_HI  = 3'd2;
	localparam logic [2:0] HDR_REQ_LO  = 3'd3;
	localparam logic [2:0] HDR_LEN_HI  = 3'd4;
	localparam logic [2:0] HDR_LEN_LO  = 3'd5;
	localparam logic [2:0] HDR_PAD     = 3'd6;
	localparam logic [2:0] HDR_LAST    = 3'(frsp_pkg::HEADER_LEN - 1);
	// end body: four status bytes, then the protocol status
	localparam logic [2:0] BODY_PROTO  = 3'd4;
	localparam logic [2:0] BODY_SAT    = 3'd5;

	frsp_pkg::phase_t phase_q, phase_d;
	logic [2:0]  hdr_idx_q, hdr_idx_d;
	logic [7:0]  rec_type_q, rec_type_d;
	logic [15:0] cur_req_q, cur_req_d;
	logic [15:0] content_left_q, content_left_d;
	logic [7:0]  padding_left_q, padding_left_d;
	logic [2:0]  body_idx_q, body_idx_d;
	logic [31:0] status_q, status_d;
	logic [7:0]  proto_q, proto_d;
	logic [15:0] cl_dec;
	logic [7:0]  pl_dec;
	logic        res_valid;
	logic        accept;
	frsp_pkg::rec_t res;

	// request taken whenever the queue has room
	assign in_stall = fifo_full;
	assign accept   = in_valid && !fifo_full;
	assign push     = accept && res_valid;
	assign push_rec = res;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= frsp_pkg::PH_HEADER;
			hdr_idx_q      <= '0;
			rec_type_q     <= '0;
			cur_req_q      <= '0;
			content_left_q <= '0;
			padding_left_q <= '0;
			body_idx_q     <= '0;
			status_q       <= '0;
			proto_q        <= '0;
		end else if (accept) begin
			phase_q        <= phase_d;
			hdr_idx_q      <= hdr_idx_d;
			rec_type_q     <= rec_type_d;
			cur_req_q      <= cur_req_d;
			content_left_q <= content_left_d;
			padding_left_q <= padding_left_d;
			body_idx_q     <= body_idx_d;
			status_q       <= status_d;
			proto_q        <= proto_d;
		end
	end

	// next state and result for the byte at the input
	always_comb begin
		phase_d        = phase_q;
		hdr_idx_d      = hdr_idx_q;
		rec_type_d     = rec_type_q;
		cur_req_d      = cur_req_q;
		content_left_d = content_left_q;
		padding_left_d = padding_left_q;
		body_idx_d     = body_idx_q;
		status_d       = status_q;
		proto_d        = proto_q;
		cl_dec         = content_left_q - 16'd1;
		pl_dec         = padding_left_q - 8'd1;
		res_valid      = 1'b0;
		res            = '0;
		res.request_tag = cur_req_q;
		case (phase_q)
			frsp_pkg::PH_CONTENT: begin
				content_left_d = cl_dec;
				if (rec_type_q == frsp_pkg::TYPE_STDOUT ||
				    rec_type_q == frsp_pkg::TYPE_STDERR) begin
					res_valid       = 1'b1;
					res.data_byte   = stream_byte;
					res.kind        = (rec_type_q == frsp_pkg::TYPE_STDOUT) ?
					                  frsp_pkg::KIND_STDOUT : frsp_pkg::KIND_STDERR;
					res.record_last = (cl_dec == 16'd0);
				end else if (rec_type_q == frsp_pkg::TYPE_END_REQUEST) begin
					if (body_idx_q < BODY_PROTO) begin
						status_d = {status_q[23:0], stream_byte};
					end else if (body_idx_q == BODY_PROTO) begin
						proto_d = stream_byte;
					end
					if (cl_dec == 16'd0) begin
						res_valid           = 1'b1;
						res.kind            = frsp_pkg::KIND_END;
						res.record_last     = 1'b1;
						res.app_status      = status_d;
						res.protocol_status = proto_d;
					end
				end
				// saturating count, only positions up to the protocol byte matter
				if (body_idx_q < BODY_SAT) begin
					body_idx_d = body_idx_q + 3'd1;
				end
				if (cl_dec == 16'd0) begin
					phase_d = (padding_left_q != 8'd0) ? frsp_pkg::PH_PADDING :
					          frsp_pkg::PH_HEADER;
				end
			end
			frsp_pkg::PH_PADDING: begin
				padding_left_d = pl_dec;
				if (pl_dec == 8'd0) begin
					phase_d = frsp_pkg::PH_HEADER;
				end
			end
			default: begin
				// header phase, unused phase code acts the same
				case (hdr_idx_q)
					HDR_TYPE:   rec_type_d = stream_byte;
					HDR_REQ_HI: cur_req_d = {stream_byte, cur_req_q[7:0]};
					HDR_REQ_LO: cur_req_d = {cur_req_q[15:8], stream_byte};
					HDR_LEN_HI: content_left_d = {stream_byte, content_left_q[7:0]};
					HDR_LEN_LO: content_left_d = {content_left_q[15:8], stream_byte};
					HDR_PAD:    padding_left_d = stream_byte;
					default:    ;
				endcase
				if (hdr_idx_q == HDR_LAST) begin
					hdr_idx_d  = '0;
					body_idx_d = '0;
					status_d   = '0;
					proto_d    = '0;
					if (content_left_q != 16'd0) begin
						phase_d = frsp_pkg::PH_CONTENT;
					end else begin
						// empty end request record: event right on the header
						if (rec_type_q == frsp_pkg::TYPE_END_REQUEST) begin
							res_valid       = 1'b1;
							res.kind        = frsp_pkg::KIND_END;
							res.record_last = 1'b1;
						end
						phase_d = (padding_left_q != 8'd0) ? frsp_pkg::PH_PADDING :
						          frsp_pkg::PH_HEADER;
					end
				end else begin
					hdr_idx_d = hdr_idx_q + 3'd1;
					phase_d   = frsp_pkg::PH_HEADER;
				end
			end
		endcase
	end

endmodule

@@ hw/rtl/frsp_fifo.sv @@
// short result queue between the parser and the output stage
`include "fastcgi_record_stream_parser_unit_assert.svh"

module frsp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  frsp_pkg::rec_t  push_rec,
	input  logic            pop,
	output logic            full,
	output logic            nonempty,
	output frsp_pkg::rec_t  head_rec
);

	localparam logic [frsp_pkg::FIFO_CW-1:0] COUNT_FULL =
		frsp_pkg::FIFO_CW'(frsp_pkg::FIFO_DEPTH);

	frsp_pkg::rec_t                mem_q [frsp_pkg::FIFO_DEPTH];
	logic [frsp_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [frsp_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [frsp_pkg::FIFO_CW-1:0]  count_q;
	logic [frsp_pkg::FIFO_AW-1:0]  ptr_gap;

	assign full     = (count_q == COUNT_FULL);
	assign nonempty = (count_q != '0);
	assign head_rec = mem_q[rd_ptr_q];
	assign ptr_gap  = wr_ptr_q - rd_ptr_q;

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`FRSP_CHECK(a_count_bound, count_q <= COUNT_FULL, "queue count above depth")
	`FRSP_CHECK(a_no_overflow, !(push && full), "push into full queue")
	`FRSP_CHECK(a_no_underflow, !(pop && !nonempty), "pop from empty queue")
	`FRSP_CHECK(a_ptr_gap, full || (ptr_gap == count_q[frsp_pkg::FIFO_AW-1:0]), "queue pointers disagree with count")

endmodule

@@ hw/rtl/frsp_back.sv @@
// back part: output register that drives the result channel
module frsp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fifo_nonempty,
	input  frsp_pkg::rec_t  head_rec,
	input  logic            out_stall,
	output logic            pop,
	output logic            out_valid,
	output frsp_pkg::rec_t  out_rec
);

	logic           out_valid_q;
	frsp_pkg::rec_t out_rec_q;

	// refill when empty or when the held request leaves
	assign pop       = fifo_nonempty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= fifo_nonempty;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_rec_q <= head_rec;
		end
	end

endmodule

@@ hw/rtl/fastcgi_record_stream_parser_unit.sv @@
// top level of the fastcgi record stream parser
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  input    | in_valid / in_stall  | stream_byte
//  output   | out_valid / out_stall| data_byte kind request_tag app_status
//           |                      | protocol_status record_last
//
// one byte is taken per cycle while in_stall is low; the parser state updates once per taken byte
// a taken byte's result reaches out_valid through the queue write, then the output register
// reset is asynchronous, active low, and clears parser state, queue and output valid
// in_stall rises only when the four-entry result queue is full
// out_stall holds the output register; the parser keeps running until the queue fills
module fastcgi_record_stream_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  stream_byte,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [7:0]  data_byte,
	output logic [1:0]  kind,
	output logic [15:0] request_tag,
	output logic [31:0] app_status,
	output logic [7:0]  protocol_status,
	output logic        record_last,
	output logic        out_valid,
	input  logic        out_stall
);

	logic           push;
	logic           pop;
	logic           fifo_full;
	logic           fifo_nonempty;
	frsp_pkg::rec_t push_rec;
	frsp_pkg::rec_t head_rec;
	frsp_pkg::rec_t out_rec;

	// parser
	frsp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream_byte (stream_byte),
		.in_valid    (in_valid),
		.fifo_full   (fifo_full),
		.in_stall    (in_stall),
		.push        (push),
		.push_rec    (push_rec)
	);

	// result queue
	frsp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.full     (fifo_full),
		.nonempty (fifo_nonempty),
		.head_rec (head_rec)
	);

	// output stage
	frsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fifo_nonempty (fifo_nonempty),
		.head_rec      (head_rec),
		.out_stall     (out_stall),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_rec       (out_rec)
	);

	// result fields
	assign data_byte       = out_rec.data_byte;
	assign kind            = out_rec.kind;
	assign request_tag     = out_rec.request_tag;
	assign app_status      = out_rec.app_status;
	assign protocol_status = out_rec.protocol_status;
	assign record_last     = out_rec.record_last;

endmodule
